>>> hdl/fmbs_pkg.sv
//------------------------------------------------------------------------------
// fmbs_pkg
// Shared types and constants for the FM-index backward search block.
//------------------------------------------------------------------------------
package fmbs_pkg;

    localparam int unsigned MAX_ROWS_DEF   = 65536;
    localparam int unsigned MAX_BLOCKS_DEF = 1024;
    localparam int unsigned ALPHABET_DEF   = 257;

    localparam int unsigned CNT_W = 17;
    localparam int unsigned SYM_W = 9;

    // Input commands
    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_BWT   = 2'd1;
    localparam logic [1:0] CMD_CKPT  = 2'd2;
    localparam logic [1:0] CMD_START = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [1:0] REG_STEP      = 2'd1;
    localparam logic [1:0] REG_BLOCKS    = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] row_index;
        logic [9:0]  block_index;
        logic [8:0]  symbol;
        logic [16:0] count_value;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [16:0] interval_low;
        logic [16:0] interval_high;
        logic [16:0] row_span;
        logic        status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START_RD,
        ST_OCC_SETUP,
        ST_BLOCK,
        ST_CKPT_RD,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_NEXT,
        ST_FINISH,
        ST_OUT
    } state_t;

endpackage

>>> hdl/fmbs_ram.sv
//------------------------------------------------------------------------------
// fmbs_ram
// Single port write, single port read RAM with a registered read.
//------------------------------------------------------------------------------
module fmbs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/fm_index_backward_search.sv
//------------------------------------------------------------------------------
// fm_index_backward_search
// FM-index backward search with checkpointed occurrence counts in RAM.
//------------------------------------------------------------------------------
// channel | direction | handshake               | payload
// in      | input     | in_valid / in_ready     | in_data  (fmbs_pkg::in_item_t)
// out     | output    | out_valid / out_ready   | out_data (fmbs_pkg::out_item_t)
// cfg     | input     | cfg_we                  | cfg_index, cfg_data
//
// A load item is written as it is accepted; the block stays ready for the
// next item. An occurrence count runs setup, 17 divider steps and the block
// start, checkpoint read, one BWT entry per cycle, a drain when the scan is
// not empty, and update. A query byte runs accept, start read, two counts
// and finish, plus an output step on the last byte. A skipped byte (empty
// interval or symbol outside the alphabet) goes from accept to finish.
// One item is worked at a time; a result waits in the output register while
// later items are taken, and a query ending while it is full stalls there.
// Reset needs no clearing pass: stores are undefined until written.
//------------------------------------------------------------------------------
module fm_index_backward_search #(
    parameter int unsigned MAX_ROWS   = fmbs_pkg::MAX_ROWS_DEF,
    parameter int unsigned MAX_BLOCKS = fmbs_pkg::MAX_BLOCKS_DEF,
    parameter int unsigned ALPHABET   = fmbs_pkg::ALPHABET_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fmbs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fmbs_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [16:0]         cfg_data
);

    localparam int unsigned RA_W  = $clog2(MAX_ROWS);
    localparam int unsigned SA_W  = $clog2(ALPHABET);
    localparam int unsigned CK_D  = MAX_BLOCKS * ALPHABET;
    localparam int unsigned CA_W  = $clog2(CK_D);
    localparam int unsigned CW    = fmbs_pkg::CNT_W;
    localparam logic [CW-1:0] SAT = {CW{1'b1}};
    localparam logic [CW:0] MAXR  = (CW + 1)'(MAX_ROWS);

    // Configuration registers
    logic [16:0] row_count_reg;
    logic [16:0] step_reg;
    logic [10:0] num_blocks_reg;

    // Query state
    fmbs_pkg::state_t state_reg, state_next;
    fmbs_pkg::in_item_t item_reg;
    logic [CW-1:0] cur_low_reg, cur_high_reg;
    logic          empty_reg, error_reg, bad_reg;
    logic          side_reg;                 // 0: low end, 1: high end
    logic [CW-1:0] lo_new_reg;
    logic [CW-1:0] start_val_reg;
    logic [CW-1:0] pos_reg;                  // saturated position
    logic [CW-1:0] quo_reg, rem_reg;         // division pos / step
    logic [4:0]    div_cnt_reg;
    logic [CW:0]   scan_i_reg;               // current BWT position
    logic [CW:0]   total_reg;
    logic          out_valid_reg;
    fmbs_pkg::out_item_t out_reg;

    logic [16:0] step_eff;
    assign step_eff = (step_reg == '0) ? 17'd1 : step_reg;

    // Stores
    logic            bwt_we, ck_we, st_we;
    logic [RA_W-1:0] bwt_raddr;
    logic [8:0]      bwt_rdata;
    logic [CA_W-1:0] ck_raddr, ck_waddr;
    logic [CW-1:0]   ck_rdata;
    logic [SA_W-1:0] st_raddr;
    logic [CW-1:0]   st_rdata;

    logic accept;
    logic out_free;
    assign in_ready = (state_reg == fmbs_pkg::ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign bwt_we = accept && in_data.cmd == fmbs_pkg::CMD_BWT
                    && ({1'b0, in_data.row_index} < 17'(MAX_ROWS));
    assign ck_we  = accept && in_data.cmd == fmbs_pkg::CMD_CKPT
                    && (32'(in_data.block_index) < 32'(MAX_BLOCKS))
                    && (32'(in_data.symbol) < 32'(ALPHABET));
    assign st_we  = accept && in_data.cmd == fmbs_pkg::CMD_START
                    && (32'(in_data.symbol) < 32'(ALPHABET));
    assign ck_waddr = CA_W'(32'(in_data.block_index) * ALPHABET + 32'(in_data.symbol));
    assign ck_raddr = CA_W'(32'(quo_reg) * ALPHABET + 32'(item_reg.symbol));
    assign bwt_raddr = RA_W'(scan_i_reg);
    assign st_raddr = SA_W'(item_reg.symbol);

    fmbs_ram #(.WIDTH(9), .DEPTH(MAX_ROWS)) u_bwt (
        .clk(clk), .we(bwt_we), .waddr(RA_W'(in_data.row_index)),
        .wdata(in_data.symbol), .raddr(bwt_raddr), .rdata(bwt_rdata));
    fmbs_ram #(.WIDTH(CW), .DEPTH(CK_D)) u_ckpt (
        .clk(clk), .we(ck_we), .waddr(ck_waddr), .wdata(in_data.count_value),
        .raddr(ck_raddr), .rdata(ck_rdata));
    fmbs_ram #(.WIDTH(CW), .DEPTH(ALPHABET)) u_start (
        .clk(clk), .we(st_we), .waddr(SA_W'(in_data.symbol)),
        .wdata(in_data.count_value), .raddr(st_raddr), .rdata(st_rdata));

    // Derived terms
    logic [CW-1:0] cur_pos;
    logic [CW:0]   sub_try;
    logic [CW-1:0] rem_shift;
    logic          block_ok;
    logic [CW:0]   scan_end;
    logic [CW+1:0] sum_full;
    logic [CW-1:0] sum_sat;

    assign cur_pos   = side_reg ? cur_high_reg : cur_low_reg;
    assign rem_shift = {rem_reg[CW-2:0], quo_reg[CW-1]};
    assign sub_try   = {1'b0, rem_shift} - {1'b0, step_eff};
    assign block_ok  = (quo_reg < CW'(num_blocks_reg)) && (32'(quo_reg) < 32'(MAX_BLOCKS));
    assign scan_end  = {1'b0, pos_reg};
    assign sum_full  = {2'b0, start_val_reg} + {1'b0, total_reg};
    assign sum_sat   = (sum_full > (CW + 2)'(SAT)) ? SAT : sum_full[CW-1:0];

    // Scan pipeline: the read of position i returns while i + 1 is addressed
    logic [CW:0] scan_first_reg;
    logic [CW:0] prev_i_reg;
    logic        hit_prev;
    assign hit_prev = (prev_i_reg < MAXR) && (bwt_rdata == item_reg.symbol);

    always_ff @(posedge clk)
    begin
        prev_i_reg <= scan_i_reg;
        if (state_reg == fmbs_pkg::ST_CKPT_RD)
            scan_first_reg <= scan_i_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fmbs_pkg::ST_IDLE:
            begin
                if (accept && in_data.cmd == fmbs_pkg::CMD_QUERY)
                begin
                    if (empty_reg || 32'(in_data.symbol) >= 32'(ALPHABET))
                        state_next = fmbs_pkg::ST_FINISH;
                    else
                        state_next = fmbs_pkg::ST_START_RD;
                end
            end
            fmbs_pkg::ST_START_RD:  state_next = fmbs_pkg::ST_OCC_SETUP;
            fmbs_pkg::ST_OCC_SETUP: state_next = fmbs_pkg::ST_BLOCK;
            fmbs_pkg::ST_BLOCK:
            begin
                if (div_cnt_reg == 5'd0)
                    state_next = fmbs_pkg::ST_CKPT_RD;
            end
            fmbs_pkg::ST_CKPT_RD:
            begin
                if (scan_i_reg < scan_end)
                    state_next = fmbs_pkg::ST_SCAN;
                else
                    state_next = fmbs_pkg::ST_NEXT;
            end
            fmbs_pkg::ST_SCAN:
            begin
                if (scan_i_reg + 1'b1 >= scan_end)
                    state_next = fmbs_pkg::ST_SCAN_LAST;
            end
            fmbs_pkg::ST_SCAN_LAST: state_next = fmbs_pkg::ST_NEXT;
            fmbs_pkg::ST_NEXT:
            begin
                if (side_reg)
                    state_next = fmbs_pkg::ST_FINISH;
                else
                    state_next = fmbs_pkg::ST_OCC_SETUP;
            end
            fmbs_pkg::ST_FINISH:
            begin
                if (item_reg.last)
                    state_next = fmbs_pkg::ST_OUT;
                else
                    state_next = fmbs_pkg::ST_IDLE;
            end
            fmbs_pkg::ST_OUT:
            begin
                // hold until the output register can take the result
                if (out_free)
                    state_next = fmbs_pkg::ST_IDLE;
            end
            default:                state_next = fmbs_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    // Control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fmbs_pkg::ST_IDLE;
            row_count_reg  <= 17'd1;
            step_reg       <= 17'd64;
            num_blocks_reg <= 11'd1024;
            cur_low_reg    <= '0;
            cur_high_reg   <= 17'd1;
            empty_reg      <= 1'b0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fmbs_pkg::ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    fmbs_pkg::REG_ROW_COUNT:
                    begin
                        row_count_reg <= cfg_data;
                        cur_low_reg   <= '0;
                        cur_high_reg  <= cfg_data;
                        empty_reg     <= 1'b0;
                        error_reg     <= 1'b0;
                    end
                    fmbs_pkg::REG_STEP:   step_reg <= cfg_data;
                    fmbs_pkg::REG_BLOCKS: num_blocks_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                fmbs_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= in_data;
                        if (in_data.cmd == fmbs_pkg::CMD_QUERY && !empty_reg
                            && 32'(in_data.symbol) >= 32'(ALPHABET))
                            error_reg <= 1'b1;
                    end
                    side_reg <= 1'b0;
                    bad_reg  <= 1'b0;
                end
                fmbs_pkg::ST_START_RD: ;
                fmbs_pkg::ST_OCC_SETUP:
                begin
                    if (!side_reg)
                        start_val_reg <= st_rdata;
                    pos_reg     <= (cur_pos > row_count_reg) ? row_count_reg : cur_pos;
                    quo_reg     <= (cur_pos > row_count_reg) ? row_count_reg : cur_pos;
                    rem_reg     <= '0;
                    div_cnt_reg <= 5'(CW);
                end
                fmbs_pkg::ST_BLOCK:
                begin
                    if (div_cnt_reg != 5'd0)
                    begin
                        div_cnt_reg <= div_cnt_reg - 5'd1;
                        if (!sub_try[CW])
                        begin
                            rem_reg <= sub_try[CW-1:0];
                            quo_reg <= {quo_reg[CW-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_shift;
                            quo_reg <= {quo_reg[CW-2:0], 1'b0};
                        end
                    end
                    else
                    begin
                        // block start = pos - (pos mod step)
                        scan_i_reg <= {1'b0, pos_reg} - {1'b0, rem_reg};
                    end
                end
                fmbs_pkg::ST_CKPT_RD:
                begin
                    if (block_ok)
                        total_reg <= {1'b0, ck_rdata};
                    else
                    begin
                        total_reg <= '0;
                        bad_reg   <= 1'b1;
                    end
                    scan_i_reg <= scan_i_reg;
                end
                fmbs_pkg::ST_SCAN:
                begin
                    scan_i_reg <= scan_i_reg + 1'b1;
                end
                fmbs_pkg::ST_SCAN_LAST: ;
                fmbs_pkg::ST_NEXT:
                begin
                    side_reg   <= 1'b1;
                    lo_new_reg <= sum_sat;
                    if (side_reg)
                    begin
                        cur_low_reg <= lo_new_reg;
                        if (bad_reg)
                            error_reg <= 1'b1;
                        if (lo_new_reg >= sum_sat)
                        begin
                            cur_high_reg <= lo_new_reg;
                            empty_reg    <= 1'b1;
                        end
                        else
                            cur_high_reg <= sum_sat;
                    end
                end
                fmbs_pkg::ST_FINISH: ;
                fmbs_pkg::ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_reg.interval_low     <= cur_low_reg;
                        out_reg.interval_high    <= cur_high_reg;
                        out_reg.row_span         <= cur_high_reg - cur_low_reg;
                        out_reg.status           <= error_reg;
                        cur_low_reg              <= '0;
                        cur_high_reg             <= row_count_reg;
                        empty_reg                <= 1'b0;
                        error_reg                <= 1'b0;
                    end
                end
                default: ;
            endcase

            // BWT data arrives in the cycle after its address: count the hit
            // of the previous scan position.
            if (state_reg == fmbs_pkg::ST_SCAN_LAST
                || (state_reg == fmbs_pkg::ST_SCAN && scan_i_reg != scan_first_reg))
            begin
                if (hit_prev)
                    total_reg <= total_reg + 1'b1;
            end
        end
    end

    // Checks
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != fmbs_pkg::ST_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_empty_held: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg |-> cur_low_reg == cur_high_reg)
        else $error("empty interval not held");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fmbs_pkg::ST_SCAN |-> scan_i_reg < scan_end)
        else $error("scan past position");

endmodule

>>> test/tb_fm_index_backward_search.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_fm_index_backward_search
// Self-checking bench for the FM-index backward search block. Load and query
// items are queued by a stimulus process and sent in random bursts. An
// in-bench predictor of the stores and the search interval runs on every
// accepted item. Each returned interval is checked against the oldest
// prediction while the receiver stalls on its own pattern.
//------------------------------------------------------------------------------
module tb_fm_index_backward_search;

    localparam int unsigned W17_MAX    = 131071;
    localparam int unsigned CYCLE_CAP  = 1000000;
    localparam int unsigned SETTLE_CYC = 1000;
    localparam int unsigned HOLD_CYC   = 3000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    fmbs_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    fmbs_pkg::out_item_t out_data;
    logic                cfg_we = 1'b0;
    logic [1:0]          cfg_index = fmbs_pkg::REG_ROW_COUNT;
    logic [16:0]         cfg_data = '0;

    fm_index_backward_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Items waiting to be sent, intervals waiting to come back
    fmbs_pkg::in_item_t  send_q[$];
    fmbs_pkg::out_item_t interval_q[$];
    int unsigned fail_cnt = 0;
    int unsigned cycle_cnt = 0;

    // Predicted block state
    logic [8:0]  bwt_mem [0:65535];
    int unsigned ckpt_mem [int];
    int unsigned start_mem [0:256];
    int unsigned rows_q = 1;
    int unsigned step_q = 64;
    int unsigned nblk_q = 1024;
    int unsigned low_q = 0;
    int unsigned high_q = 1;
    bit          empty_q = 1'b0;
    bit          err_q = 1'b0;

    task automatic restart_interval();
        low_q   = 0;
        high_q  = rows_q;
        empty_q = 1'b0;
        err_q   = 1'b0;
    endtask

    // start[sym] + occ(sym, pos), saturated at 17 bits
    function automatic int unsigned narrow_end(int unsigned sym, int unsigned pos,
                                               inout bit bad);
        longint unsigned v;
        int unsigned stp, p, blk, i;
        int key;
        v   = 0;
        stp = (step_q == 0) ? 1 : step_q;
        p   = (pos > rows_q) ? rows_q : pos;
        blk = p / stp;
        key = blk * fmbs_pkg::ALPHABET_DEF + sym;
        if (blk < nblk_q && blk < fmbs_pkg::MAX_BLOCKS_DEF)
            v = ckpt_mem.exists(key) ? ckpt_mem[key] : 0;
        else
            bad = 1'b1;
        for (i = blk * stp; i < p; i++)
            if (i < fmbs_pkg::MAX_ROWS_DEF && bwt_mem[i] == sym)
                v++;
        v += start_mem[sym];
        return (v > W17_MAX) ? W17_MAX : int'(v);
    endfunction

    // Update the predicted state for one accepted item
    task automatic apply_item(input fmbs_pkg::in_item_t it);
        fmbs_pkg::out_item_t res;
        bit                  bad;
        int unsigned         lo, hi;
        case (it.cmd)
            fmbs_pkg::CMD_BWT:
                bwt_mem[it.row_index] = it.symbol;
            fmbs_pkg::CMD_CKPT:
                if (it.symbol < fmbs_pkg::ALPHABET_DEF)
                    ckpt_mem[int'(it.block_index) * fmbs_pkg::ALPHABET_DEF + it.symbol]
                        = it.count_value;
            fmbs_pkg::CMD_START:
                if (it.symbol < fmbs_pkg::ALPHABET_DEF)
                    start_mem[it.symbol] = it.count_value;
            default:
            begin
                if (!empty_q) begin
                    if (it.symbol >= fmbs_pkg::ALPHABET_DEF) begin
                        err_q = 1'b1;
                    end else begin
                        bad = 1'b0;
                        lo  = narrow_end(it.symbol, low_q, bad);
                        hi  = narrow_end(it.symbol, high_q, bad);
                        if (bad)
                            err_q = 1'b1;
                        low_q  = lo;
                        high_q = hi;
                        if (lo >= hi) begin
                            high_q  = lo;
                            empty_q = 1'b1;
                        end
                    end
                end
                if (it.last) begin
                    res.interval_low  = low_q[16:0];
                    res.interval_high = high_q[16:0];
                    res.row_span      = 17'(high_q - low_q);
                    res.status        = err_q;
                    interval_q.insert(interval_q.size(), res);
                    restart_interval();
                end
            end
        endcase
    endtask

    // Sender: bursts of random length with random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(posedge clk or negedge rst_n) begin
        logic nxt_valid;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (in_valid)
                apply_item(in_data);
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (send_q.size() > 0) begin
                nxt_valid = 1'b1;
                in_data <= send_q.pop_front();
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = 0;
                        1:       gap_left = $urandom_range(20, 200);
                        default: gap_left = $urandom_range(0, 4);
                    endcase
                end
            end
            in_valid <= nxt_valid;
        end
    end

    // Receiver: checks intervals, stalls on a pattern, one long hold-off
    int unsigned rx_cnt = 0;
    int unsigned hold_left = 0;
    int unsigned stall_mode = 0;

    function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
            fail_cnt++;
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        fmbs_pkg::out_item_t exp_r;
        logic                nxt_ready;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                rx_cnt++;
                if (interval_q.size() == 0) begin
                    $display("%0t unexpected interval: expected none, got %p", $time, out_data);
                    fail_cnt++;
                end else begin
                    exp_r = interval_q.pop_front();
                    check_field("interval_low", exp_r.interval_low, out_data.interval_low);
                    check_field("interval_high", exp_r.interval_high, out_data.interval_high);
                    check_field("row_span", exp_r.row_span, out_data.row_span);
                    check_field("status", exp_r.status, out_data.status);
                end
                if (rx_cnt == 20)
                    hold_left = HOLD_CYC;
            end
            if (cycle_cnt % 64 == 0)
                stall_mode = $urandom_range(0, 2);
            if (hold_left > 0) begin
                hold_left--;
                nxt_ready = 1'b0;
            end else begin
                case (stall_mode)
                    0:       nxt_ready = 1'b1;
                    1:       nxt_ready = $urandom_range(0, 1);
                    default: nxt_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
            out_ready <= nxt_ready;
        end
    end

    // Run limit
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_CAP) begin
            $display("[fm_index_backward_search] ERROR");
            $finish;
        end
    end

    // Stimulus helpers
    task automatic queue_item(logic [1:0] cmd, int unsigned row, int unsigned blk,
                              int unsigned sym, int unsigned val, bit last);
        fmbs_pkg::in_item_t it;
        it.cmd         = cmd;
        it.row_index   = row[15:0];
        it.block_index = blk[9:0];
        it.symbol      = sym[8:0];
        it.count_value = val[16:0];
        it.last        = last;
        send_q.insert(send_q.size(), it);
    endtask

    // Query byte with random don't-care fields
    task automatic queue_byte(int unsigned sym, bit last);
        queue_item(fmbs_pkg::CMD_QUERY, $urandom_range(0, 65535), $urandom_range(0, 1023),
                   sym, $urandom_range(0, W17_MAX), last);
    endtask

    // Wait until nothing is pending, then let any quiet work finish
    task automatic settle();
        while (send_q.size() > 0 || in_valid || interval_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int unsigned val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[16:0];
        case (idx)
            fmbs_pkg::REG_ROW_COUNT:
            begin
                rows_q = val & W17_MAX;
                restart_interval();
            end
            fmbs_pkg::REG_STEP: step_q = val & W17_MAX;
            default:            nblk_q = val & 11'h7FF;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // One random phase: configure, load the stores, then run queries
    task automatic random_phase(int unsigned rows, int unsigned stp, int unsigned nblk);
        int unsigned syms [0:2];
        int unsigned eff_step, top_blk, b, s, r, q, n, k;
        settle();
        write_reg(fmbs_pkg::REG_ROW_COUNT, rows);
        write_reg(fmbs_pkg::REG_STEP, stp);
        write_reg(fmbs_pkg::REG_BLOCKS, nblk);
        for (s = 0; s < 3; s++)
            syms[s] = ($urandom_range(0, 7) == 0) ? 256 : $urandom_range(0, 255);
        // BWT rows in use, mostly from the phase symbols
        for (r = 0; r < rows; r++)
            queue_item(fmbs_pkg::CMD_BWT, r, $urandom_range(0, 1023),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(0, 256)
                                                   : syms[$urandom_range(0, 2)],
                       $urandom_range(0, W17_MAX), $urandom_range(0, 1));
        // Start counts and checkpoints for every block a query can reach
        for (s = 0; s < 3; s++)
            queue_item(fmbs_pkg::CMD_START, $urandom_range(0, 65535), $urandom_range(0, 1023),
                       syms[s], $urandom_range(0, rows), $urandom_range(0, 1));
        eff_step = (stp == 0) ? 1 : stp;
        top_blk  = rows / eff_step;
        if (top_blk > fmbs_pkg::MAX_BLOCKS_DEF - 1)
            top_blk = fmbs_pkg::MAX_BLOCKS_DEF - 1;
        for (b = 0; b <= top_blk; b++)
            for (s = 0; s < 3; s++)
                queue_item(fmbs_pkg::CMD_CKPT, $urandom_range(0, 65535), b, syms[s],
                           $urandom_range(0, rows / 2 + 1), $urandom_range(0, 1));
        // Ignored writes and far-away rows
        queue_item(fmbs_pkg::CMD_START, 0, 0, $urandom_range(257, 511),
                   $urandom_range(0, W17_MAX), 0);
        queue_item(fmbs_pkg::CMD_CKPT, 0, $urandom_range(0, 1023), $urandom_range(257, 511),
                   $urandom_range(0, W17_MAX), 1);
        queue_item(fmbs_pkg::CMD_BWT, $urandom_range(32768, 65535), 0,
                   $urandom_range(0, 511), 0, 0);
        // Queries of one to five bytes
        n = $urandom_range(6, 10);
        for (q = 0; q < n; q++) begin
            k = $urandom_range(1, 5);
            for (r = 0; r < k; r++)
                queue_byte(($urandom_range(0, 15) == 0) ? $urandom_range(257, 511)
                                                        : syms[$urandom_range(0, 2)],
                           r == k - 1);
        end
    endtask

    initial begin
        int unsigned ph, rows, stp, nblk;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one row holding the sentinel
        queue_item(fmbs_pkg::CMD_BWT, 0, 0, 256, 0, 0);
        queue_item(fmbs_pkg::CMD_START, 0, 0, 256, 0, 0);
        queue_item(fmbs_pkg::CMD_START, 0, 0, 65, 1, 0);
        queue_item(fmbs_pkg::CMD_CKPT, 0, 0, 256, 0, 0);
        queue_item(fmbs_pkg::CMD_CKPT, 0, 0, 65, 0, 0);
        queue_item(fmbs_pkg::CMD_CKPT, 65535, 1023, 0, 5, 1);
        queue_byte(256, 1'b1);              // full match of the sentinel
        queue_byte(65, 1'b1);               // empty interval
        queue_byte(511, 1'b1);              // symbol beyond alphabet
        queue_byte(65, 1'b0);               // empty, later byte ignored
        queue_byte(256, 1'b1);

        // Largest row count: sum saturation and block beyond range
        settle();
        write_reg(fmbs_pkg::REG_ROW_COUNT, 65536);
        write_reg(fmbs_pkg::REG_STEP, 64);
        write_reg(fmbs_pkg::REG_BLOCKS, 1024);
        queue_item(fmbs_pkg::CMD_START, 0, 0, 0, 65536, 0);
        queue_item(fmbs_pkg::CMD_CKPT, 0, 0, 0, 65536, 0);
        queue_item(fmbs_pkg::CMD_START, 0, 0, 255, 100, 0);
        queue_item(fmbs_pkg::CMD_CKPT, 0, 0, 255, 0, 0);
        queue_byte(0, 1'b1);
        queue_byte(255, 1'b1);

        // Random phases, extremes of step and block count first
        for (ph = 0; ph < 7; ph++) begin
            rows = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
            stp  = $urandom_range(1, rows + 2);
            nblk = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 1024;
            case (ph)
                0:       stp  = 0;
                1:       stp  = 65536;
                2:       nblk = 1;
                3:       stp  = 1;
                default: ;
            endcase
            random_phase(rows, stp, nblk);
        end

        settle();
        if (fail_cnt == 0)
            $display("[fm_index_backward_search] OK");
        else
            $display("[fm_index_backward_search] ERROR");
        $finish;
    end

endmodule
